@@ rtl/core/hipm_pkg.sv @@
// shared types, widths and register codes of the inverse pixel mapper
package hipm_pkg;

  localparam int COORD_WIDTH = 13;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 3;

  // widest of the coordinate and the 14-bit source size fields
  localparam int CW_EXT = (COORD_WIDTH > 14) ? COORD_WIDTH : 14;
  // column after offset, signed
  localparam int UW = CW_EXT + 2;
  // row, signed
  localparam int VW = COORD_WIDTH + 1;
  // product of a 32-bit coefficient and a coordinate
  localparam int PW = 32 + UW;
  // three-term sum
  localparam int SW = PW + 2;
  // sum after sign flip
  localparam int FW = SW + 1;
  // dividend and remainder width, room for numerator * 2^13 and divisor << COORD_WIDTH
  localparam int RW = FW + 2 + ((COORD_WIDTH > 13) ? COORD_WIDTH : 13);
  // cycles from accepting edge to result edge
  localparam int LATENCY = COORD_WIDTH + 7;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROW0_LINEAR   = 3'd0,
    CFG_ROW1_LINEAR   = 3'd1,
    CFG_TRANSLATION   = 3'd2,
    CFG_PERSPECTIVE   = 3'd3,
    CFG_DEN_BIAS      = 3'd4,
    CFG_COLUMN_OFFSET = 3'd5,
    CFG_SOURCE_WIDTH  = 3'd6,
    CFG_SOURCE_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] out_col;
    logic [COORD_WIDTH-1:0] out_row;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] src_col;
    logic [COORD_WIDTH-1:0] src_row;
    logic                   inside_res;
  } pix_out_t;

endpackage

@@ rtl/core/hipm_div_stage.sv @@
// one quotient bit of the pipelined restoring divider
module hipm_div_stage #(
  parameter int BIT_POS = 0
) (
  input  logic                             clk,
  input  logic [hipm_pkg::RW-1:0]          rem_in,
  input  logic [hipm_pkg::RW-1:0]          div_in,
  input  logic [hipm_pkg::COORD_WIDTH-1:0] quo_in,
  output logic [hipm_pkg::RW-1:0]          rem,
  output logic [hipm_pkg::COORD_WIDTH-1:0] quo
);

  logic [hipm_pkg::RW-1:0]          trial;
  logic                             fits;
  logic [hipm_pkg::COORD_WIDTH-1:0] bit_mask;

  assign trial    = div_in << BIT_POS;
  assign fits     = rem_in >= trial;
  assign bit_mask = hipm_pkg::COORD_WIDTH'(1) << BIT_POS;

  always_ff @(posedge clk) begin
    rem <= fits ? (rem_in - trial) : rem_in;
    quo <= fits ? (quo_in | bit_mask) : quo_in;
  end

endmodule

@@ rtl/core/homography_inverse_pixel_mapper.sv @@
// top level of the inverse homography pixel mapper
//
// usage
//   one output pixel (out_col, out_row) enters on pix_in at each edge where start
//   is high and busy is low; a new transfer may start in every cycle
//   done strobes for one cycle with src_col, src_row and inside_res on pix_out;
//   results leave in the order the pixels came in, one per pixel
// throughput and pipeline
//   one pixel per clock outside reset, set by the fully pipelined datapath:
//   offset add, six parallel multipliers, three sums, sign fix, numerator
//   scaling, range test, then one restoring divider stage per quotient bit,
//   then the bound test
// config
//   cfg_we writes cfg_wdata into the register cfg_addr in the same edge;
//   write only while no pixel is in flight
// reset
//   rst is synchronous; it empties the pipeline and loads the identity mapping,
//   zero column offset and a 1024 x 1024 source; busy is high during reset
// backpressure
//   none, the receiver must take every result in its done cycle
module homography_inverse_pixel_mapper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  hipm_pkg::pix_in_t                 pix_in,
  output logic                              done,
  output hipm_pkg::pix_out_t                pix_out,
  input  logic                              cfg_we,
  input  logic [hipm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hipm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW = hipm_pkg::COORD_WIDTH;
  localparam int UW = hipm_pkg::UW;
  localparam int VW = hipm_pkg::VW;
  localparam int PW = hipm_pkg::PW;
  localparam int SW = hipm_pkg::SW;
  localparam int FW = hipm_pkg::FW;
  localparam int RW = hipm_pkg::RW;
  localparam int XW = hipm_pkg::CW_EXT;

  // configuration registers
  logic signed [31:0] h00, h01, h10, h11, h02, h12, h20, h21, h22;
  logic signed [14:0] col_off;
  logic [13:0]        src_w, src_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      h00     <= 32'sd16777216;
      h01     <= '0;
      h10     <= '0;
      h11     <= 32'sd16777216;
      h02     <= '0;
      h12     <= '0;
      h20     <= '0;
      h21     <= '0;
      h22     <= 32'sd16777216;
      col_off <= '0;
      src_w   <= 14'd1024;
      src_h   <= 14'd1024;
    end else if (cfg_we) begin
      unique case (hipm_pkg::cfg_idx_t'(cfg_addr))
        hipm_pkg::CFG_ROW0_LINEAR: begin
          h00 <= cfg_wdata[63:32];
          h01 <= cfg_wdata[31:0];
        end
        hipm_pkg::CFG_ROW1_LINEAR: begin
          h10 <= cfg_wdata[63:32];
          h11 <= cfg_wdata[31:0];
        end
        hipm_pkg::CFG_TRANSLATION: begin
          h02 <= cfg_wdata[63:32];
          h12 <= cfg_wdata[31:0];
        end
        hipm_pkg::CFG_PERSPECTIVE: begin
          h20 <= cfg_wdata[63:32];
          h21 <= cfg_wdata[31:0];
        end
        hipm_pkg::CFG_DEN_BIAS:      h22     <= cfg_wdata[31:0];
        hipm_pkg::CFG_COLUMN_OFFSET: col_off <= cfg_wdata[14:0];
        hipm_pkg::CFG_SOURCE_WIDTH:  src_w   <= cfg_wdata[13:0];
        hipm_pkg::CFG_SOURCE_HEIGHT: src_h   <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  // every cycle is open for a new pixel outside reset
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // stage valid bits
  logic v1, v2, v3, v4, v5;
  logic [CW:0] vdiv;

  // stage 1: apply column offset
  logic signed [UW-1:0] u1;
  logic signed [VW-1:0] r1;

  // stage 2: products
  logic signed [PW-1:0] p00, p01, p10, p11, p20, p21;

  // stage 3: numerators and denominator, numerators at 2^24, denominator at 2^36
  logic signed [SW-1:0] nx3, ny3, den3;

  // stage 4: make the denominator positive
  logic signed [FW-1:0] sx4, sy4, dd4;
  logic                 dz4;

  // stage 5: dividend and divisor for floor(num * 2^12 / den + 0.5)
  logic signed [RW-1:0] nx5, ny5, d5;
  logic                 dz5;

  // divider pipeline, index 0 is loaded by the range test stage
  logic [RW-1:0] rem_x [CW+1];
  logic [RW-1:0] rem_y [CW+1];
  logic [CW-1:0] quo_x [CW+1];
  logic [CW-1:0] quo_y [CW+1];
  logic [RW-1:0] div_p [CW+1];
  logic [CW:0]   ok_p;

  logic range_ok;
  assign range_ok = !dz5 && !nx5[RW-1] && !ny5[RW-1]
                    && (nx5 < (d5 <<< CW)) && (ny5 < (d5 <<< CW));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      vdiv <= '0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      vdiv <= {vdiv[CW-1:0], v5};
      done <= vdiv[CW];
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    u1 <= UW'(signed'({1'b0, pix_in.out_col})) + UW'(col_off);
    r1 <= signed'({1'b0, pix_in.out_row});
    // stage 2
    p00 <= h00 * u1;
    p01 <= h01 * r1;
    p10 <= h10 * u1;
    p11 <= h11 * r1;
    p20 <= h20 * u1;
    p21 <= h21 * r1;
    // stage 3
    nx3  <= SW'(p00) + SW'(p01) + (SW'(h02) <<< 8);
    ny3  <= SW'(p10) + SW'(p11) + (SW'(h12) <<< 8);
    den3 <= SW'(p20) + SW'(p21) + (SW'(h22) <<< 12);
    // stage 4: flip the numerators and the denominator when the denominator is negative
    sx4 <= den3[SW-1] ? -FW'(nx3) : FW'(nx3);
    sy4 <= den3[SW-1] ? -FW'(ny3) : FW'(ny3);
    dd4 <= den3[SW-1] ? -FW'(den3) : FW'(den3);
    dz4 <= (den3 == '0);
    // stage 5
    nx5 <= (RW'(sx4) <<< 13) + RW'(dd4);
    ny5 <= (RW'(sy4) <<< 13) + RW'(dd4);
    d5  <= RW'(dd4) <<< 1;
    dz5 <= dz4;
    // range test: quotient must lie in 0 .. 2^COORD_WIDTH-1 for both axes
    ok_p[0]  <= range_ok;
    rem_x[0] <= range_ok ? unsigned'(nx5) : '0;
    rem_y[0] <= range_ok ? unsigned'(ny5) : '0;
    quo_x[0] <= '0;
    quo_y[0] <= '0;
    div_p[0] <= unsigned'(d5);
  end

  for (genvar i = 0; i < CW; i++) begin : g_div
    hipm_div_stage #(.BIT_POS(CW - 1 - i)) u_div_x (
      .clk    (clk),
      .rem_in (rem_x[i]),
      .div_in (div_p[i]),
      .quo_in (quo_x[i]),
      .rem    (rem_x[i+1]),
      .quo    (quo_x[i+1])
    );
    hipm_div_stage #(.BIT_POS(CW - 1 - i)) u_div_y (
      .clk    (clk),
      .rem_in (rem_y[i]),
      .div_in (div_p[i]),
      .quo_in (quo_y[i]),
      .rem    (rem_y[i+1]),
      .quo    (quo_y[i+1])
    );
    always_ff @(posedge clk) begin
      div_p[i+1] <= div_p[i];
      ok_p[i+1]  <= ok_p[i];
    end
  end

  // bound test against the source size
  logic in_bounds;
  assign in_bounds = ok_p[CW]
                     && (XW'(quo_x[CW]) < XW'(src_w))
                     && (XW'(quo_y[CW]) < XW'(src_h));

  always_ff @(posedge clk) begin
    pix_out.src_col    <= in_bounds ? quo_x[CW] : '0;
    pix_out.src_row    <= in_bounds ? quo_y[CW] : '0;
    pix_out.inside_res <= in_bounds;
  end

endmodule

@@ rtl/core/hipm_checker.sv @@
// port-level checker of the inverse pixel mapper and its bind
module hipm_props (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input hipm_pkg::pix_out_t pix_out
);

  // every result comes from an accepted transfer at the distance given by LATENCY
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hipm_pkg::LATENCY))
    else $error("result without matching transfer");

  // outside points report zero coordinates
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !pix_out.inside_res) |-> (pix_out.src_col == '0 && pix_out.src_row == '0))
    else $error("outside point with nonzero coordinates");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

  // busy is only raised by reset
  a_busy_reset: assert property (@(posedge clk)
    busy |-> rst)
    else $error("busy outside reset");

endmodule

bind homography_inverse_pixel_mapper hipm_props u_hipm_props (.*);
